/* sv/mpc_pkg.sv */
package mpc_pkg;

   localparam logic [1:0] KIND_CPU    = 2'd0;
   localparam logic [1:0] KIND_IOAPIC = 2'd1;
   localparam logic [1:0] KIND_MAP    = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIG = 2'd1;
   localparam logic [1:0] STATUS_NO_CPUS = 2'd2;

   localparam logic [7:0] ENT_CPU      = 8'd0;
   localparam logic [7:0] ENT_IOAPIC   = 8'd2;
   localparam logic [7:0] ENT_OVERRIDE = 8'd3;

   localparam int HDR_LEN      = 44;
   localparam int HDR_COUNT_LO = 34;
   localparam int HDR_COUNT_HI = 35;
   localparam int CPU_ENT_LEN  = 20;
   localparam int ENT_LEN      = 8;
   localparam int ISA_IRQS     = 16;

   localparam logic [7:0] SIG_BYTES [4] = '{8'h50, 8'h43, 8'h4D, 8'h50};

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_ENTRY,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_MAP,
      DS_DONE
   } dump_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [7:0]  unit_id;
      logic        enabled;
      logic        boot_cpu;
      logic [31:0] mmio_base;
      logic [7:0]  gsi;
      logic [1:0]  status;
      logic [4:0]  cpu_total;
      logic [3:0]  ioapic_total;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic         rec_vld;
      rsp_item_type rec;
      logic         wr_en;
      logic [3:0]   wr_addr;
      logic [7:0]   wr_data;
      logic         fin;
      logic [4:0]   cpu_total;
      logic [3:0]   ioapic_total;
   } prs_evt_type;

endpackage

/* sv/mpc_req_if.sv */
interface mpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] table_byte;
   logic       first;

   modport source (output valid, table_byte, first, input ready);
   modport sink (input valid, table_byte, first, output ready);
endinterface

/* sv/mpc_rsp_if.sv */
interface mpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  slot;
   logic [7:0]  unit_id;
   logic        enabled;
   logic        boot_cpu;
   logic [31:0] mmio_base;
   logic [7:0]  gsi;
   logic [1:0]  status;
   logic [4:0]  cpu_total;
   logic [3:0]  ioapic_total;
   logic        last;

   modport source (output valid, kind, slot, unit_id, enabled, boot_cpu, mmio_base, gsi,
                   status, cpu_total, ioapic_total, last, input ready);
   modport sink (input valid, kind, slot, unit_id, enabled, boot_cpu, mmio_base, gsi,
                 status, cpu_total, ioapic_total, last, output ready);
endinterface

/* sv/mpc_ram.sv */
module mpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mpc_parse.sv */
module mpc_parse
   import mpc_pkg::*;
#(
   parameter int MAX_CPUS    = 16,
   parameter int MAX_IOAPICS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  table_byte,
   input  logic        first,
   output prs_evt_type evt
);

   localparam int CW = $clog2(MAX_CPUS + 1);
   localparam int IW = $clog2(MAX_IOAPICS + 1);

   phase_type   phase_ff, phase_in, cur_phase;
   logic [5:0]  hoff_ff, hoff_in, cur_hoff;
   logic [15:0] ent_ff, ent_in, ent_dec;
   logic [7:0]  typ_ff, typ_in, cur_typ;
   logic [4:0]  eoff_ff, eoff_in;
   logic [23:0] cap_ff, cap_in;
   logic [7:0]  unit_ff, unit_in;
   logic [CW-1:0] cpu_ff, cpu_in, cur_cpu;
   logic [IW-1:0] io_ff, io_in, cur_io;
   logic        last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hoff_ff  <= '0;
         ent_ff   <= '0;
         typ_ff   <= '0;
         eoff_ff  <= '0;
         cpu_ff   <= '0;
         io_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         hoff_ff  <= hoff_in;
         ent_ff   <= ent_in;
         typ_ff   <= typ_in;
         eoff_ff  <= eoff_in;
         cpu_ff   <= cpu_in;
         io_ff    <= io_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff  <= cap_in;
      unit_ff <= unit_in;
   end

   always_comb begin
      phase_in = phase_ff;
      hoff_in  = hoff_ff;
      ent_in   = ent_ff;
      typ_in   = typ_ff;
      eoff_in  = eoff_ff;
      cap_in   = cap_ff;
      unit_in  = unit_ff;
      cpu_in   = cpu_ff;
      io_in    = io_ff;
      evt      = '0;

      cur_phase = first ? PH_HEADER : phase_ff;
      cur_hoff  = first ? '0 : hoff_ff;
      cur_cpu   = first ? '0 : cpu_ff;
      cur_io    = first ? '0 : io_ff;
      cur_typ   = (eoff_ff == '0) ? table_byte : typ_ff;
      ent_dec   = ent_ff - 16'd1;
      last_byte = (cur_typ == ENT_CPU) ? (eoff_ff == 5'(CPU_ENT_LEN - 1))
                                       : (eoff_ff == 5'(ENT_LEN - 1));

      if (take) begin
         cpu_in   = cur_cpu;
         io_in    = cur_io;
         phase_in = cur_phase;
         hoff_in  = cur_hoff;
         unique case (cur_phase)
            PH_HEADER: begin
               if (cur_hoff < 6'd4 && table_byte != SIG_BYTES[cur_hoff[1:0]]) begin
                  phase_in           = PH_DONE;
                  evt.rec_vld        = 1'b1;
                  evt.rec.kind       = KIND_DONE;
                  evt.rec.status     = STATUS_BAD_SIG;
                  evt.rec.last       = 1'b1;
               end else begin
                  if (cur_hoff == 6'(HDR_COUNT_LO)) begin
                     ent_in[7:0] = table_byte;
                  end
                  if (cur_hoff == 6'(HDR_COUNT_HI)) begin
                     ent_in[15:8] = table_byte;
                  end
                  hoff_in = cur_hoff + 6'd1;
                  if (cur_hoff == 6'(HDR_LEN - 1)) begin
                     phase_in = PH_ENTRY;
                     eoff_in  = '0;
                     if (ent_ff == '0) begin
                        phase_in = PH_DONE;
                        evt.fin  = 1'b1;
                     end
                  end
               end
            end
            PH_ENTRY: begin
               if (eoff_ff == 5'd0) begin
                  typ_in = table_byte;
               end
               if (eoff_ff == 5'd1) begin
                  unit_in = table_byte;
               end
               case (eoff_ff)
                  5'd4:    cap_in[7:0]   = table_byte;
                  5'd5:    cap_in[15:8]  = table_byte;
                  5'd6:    cap_in[23:16] = table_byte;
                  default: ;
               endcase
               if (cur_typ == ENT_CPU && eoff_ff == 5'd3 && cpu_ff < CW'(MAX_CPUS)) begin
                  evt.rec_vld      = 1'b1;
                  evt.rec.kind     = KIND_CPU;
                  evt.rec.slot     = 4'(cpu_ff);
                  evt.rec.unit_id  = unit_ff;
                  evt.rec.enabled  = table_byte[0];
                  evt.rec.boot_cpu = table_byte[1];
                  cpu_in           = cpu_ff + CW'(1);
               end
               if (eoff_ff == 5'd7) begin
                  if (cur_typ == ENT_IOAPIC && io_ff < IW'(MAX_IOAPICS)) begin
                     evt.rec_vld       = 1'b1;
                     evt.rec.kind      = KIND_IOAPIC;
                     evt.rec.slot      = 4'(io_ff);
                     evt.rec.unit_id   = unit_ff;
                     evt.rec.mmio_base = {table_byte, cap_ff};
                     io_in             = io_ff + IW'(1);
                  end else if (cur_typ == ENT_OVERRIDE && cap_ff[15:8] < 8'(ISA_IRQS)) begin
                     evt.wr_en   = 1'b1;
                     evt.wr_addr = cap_ff[11:8];
                     evt.wr_data = table_byte;
                  end
               end
               if (last_byte) begin
                  eoff_in = '0;
                  ent_in  = ent_dec;
                  if (ent_dec == '0) begin
                     phase_in = PH_DONE;
                     evt.fin  = 1'b1;
                  end
               end else begin
                  eoff_in = eoff_ff + 5'd1;
               end
            end
            PH_IDLE, PH_DONE: begin
            end
         endcase
      end

      evt.cpu_total    = 5'(cpu_ff);
      evt.ioapic_total = 4'(io_ff);
   end

endmodule

/* sv/mp_config_table_parser.sv */
// Parses a multiprocessor configuration table presented one byte per transfer
// on the req_chan channel; a byte with first set restarts the parse at header
// byte 0, clears the counts and returns the ISA interrupt map to identity.
// Results leave on rsp_chan: processor and I/O APIC records, then at the end
// of the table the sixteen ISA map entries in IRQ order and a done item.
// A processor record appears in the cycle after the transfer of entry byte 3,
// an I/O APIC record in the cycle after entry byte 7, and a bad signature
// gives the done item in the cycle after the first byte that differs.
// Table bytes are taken at one per cycle while the output register is free.
// The end-of-table dump reads the interrupt map memory one entry per cycle
// while the output register is free (a first read, sixteen map items, one
// done item); no byte is taken during it.
// The output register accepts a new result in the same cycle that the held
// one is taken; while the receiver stalls, the held result stays put and
// the input channel is held off.
// After reset the block ignores bytes until one arrives with first set.
module mp_config_table_parser
   import mpc_pkg::*;
#(
   parameter int MAX_CPUS    = 16,
   parameter int MAX_IOAPICS = 8
) (
   input logic       clock,
   input logic       reset,
   mpc_req_if.sink   req_chan,
   mpc_rsp_if.source rsp_chan
);

   prs_evt_type    evt;
   logic           take, out_free;
   logic           out_vld_ff, out_vld_in;
   rsp_item_type   out_ff, out_in;
   dump_state_type ds_ff, ds_in;
   logic [3:0]     idx_ff, idx_in, rd_addr;
   logic           pend_ff, pend_in;
   logic           rd_en, rd_vld_ff;
   logic [7:0]     rd_data;
   logic [ISA_IRQS-1:0] map_vld_ff, map_vld_in;

   mpc_parse #(
      .MAX_CPUS    (MAX_CPUS),
      .MAX_IOAPICS (MAX_IOAPICS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .table_byte (req_chan.table_byte),
      .first      (req_chan.first),
      .evt        (evt)
   );

   mpc_ram #(
      .WIDTH (8),
      .DEPTH (ISA_IRQS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (evt.wr_en),
      .wr_addr (evt.wr_addr),
      .wr_data (evt.wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free       = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = (ds_ff == DS_IDLE) && out_free;
   assign take           = req_chan.valid && req_chan.ready;
   assign rd_addr        = pend_ff ? idx_ff + 4'd1 : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         ds_ff      <= DS_IDLE;
         idx_ff     <= '0;
         pend_ff    <= 1'b0;
         map_vld_ff <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         ds_ff      <= ds_in;
         idx_ff     <= idx_in;
         pend_ff    <= pend_in;
         map_vld_ff <= map_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (rd_en) begin
         rd_vld_ff <= map_vld_ff[rd_addr];
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_chan.ready;
      out_in     = out_ff;
      ds_in      = ds_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      rd_en      = 1'b0;
      map_vld_in = map_vld_ff;

      if (take && req_chan.first) begin
         map_vld_in = '0;
      end
      if (evt.wr_en) begin
         map_vld_in[evt.wr_addr] = 1'b1;
      end

      unique case (ds_ff)
         DS_IDLE: begin
            if (take) begin
               if (evt.rec_vld) begin
                  out_vld_in = 1'b1;
                  out_in     = evt.rec;
               end
               if (evt.fin) begin
                  ds_in   = DS_MAP;
                  idx_in  = '0;
                  pend_in = 1'b0;
               end
            end
         end
         DS_MAP: begin
            if (!pend_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
            end else if (out_free) begin
               out_vld_in  = 1'b1;
               out_in      = '0;
               out_in.kind = KIND_MAP;
               out_in.slot = idx_ff;
               out_in.gsi  = rd_vld_ff ? rd_data : 8'(idx_ff);
               if (idx_ff == 4'(ISA_IRQS - 1)) begin
                  ds_in   = DS_DONE;
                  pend_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 4'd1;
                  rd_en  = 1'b1;
               end
            end
         end
         DS_DONE: begin
            if (out_free) begin
               out_vld_in          = 1'b1;
               out_in              = '0;
               out_in.kind         = KIND_DONE;
               out_in.status       = (evt.cpu_total != '0) ? STATUS_OK : STATUS_NO_CPUS;
               out_in.cpu_total    = evt.cpu_total;
               out_in.ioapic_total = evt.ioapic_total;
               out_in.last         = 1'b1;
               ds_in               = DS_IDLE;
            end
         end
         default: begin
            ds_in = DS_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.kind         = out_ff.kind;
   assign rsp_chan.slot         = out_ff.slot;
   assign rsp_chan.unit_id      = out_ff.unit_id;
   assign rsp_chan.enabled      = out_ff.enabled;
   assign rsp_chan.boot_cpu     = out_ff.boot_cpu;
   assign rsp_chan.mmio_base    = out_ff.mmio_base;
   assign rsp_chan.gsi          = out_ff.gsi;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.cpu_total    = out_ff.cpu_total;
   assign rsp_chan.ioapic_total = out_ff.ioapic_total;
   assign rsp_chan.last         = out_ff.last;

`ifndef SYNTHESIS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.kind == KIND_DONE |-> out_ff.last)
      else $error("done item without last flag");

   a_fin_when_idle: assert property (@(posedge clock) disable iff (reset)
      evt.fin |-> ds_ff == DS_IDLE)
      else $error("end of table while the map dump is still running");

   a_dump_covers_map: assert property (@(posedge clock) disable iff (reset)
      ds_ff == DS_MAP && ds_in == DS_DONE |-> idx_ff == 4'(ISA_IRQS - 1))
      else $error("map dump ended before the last entry");

   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      !(evt.wr_en && rd_en))
      else $error("map write overlaps a dump read");
`endif

endmodule

/* test/mp_config_table_parser_test.sv */
`timescale 1ns / 100ps

module mp_config_table_parser_test;
   import mpc_pkg::*;

   localparam int PERIOD       = 12;
   localparam int CPU_LIMIT    = 16;
   localparam int IOAPIC_LIMIT = 8;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_BYTES  = 85;
   localparam int SEND_IDLE [4] = '{0, 87, 0, 7};
   localparam int RECV_STALL [4] = '{0, 0, 87, 7};

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpc_req_if req_chan ();
   mpc_rsp_if rsp_chan ();

   mp_config_table_parser #(
      .MAX_CPUS(CPU_LIMIT),
      .MAX_IOAPICS(IOAPIC_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #(PERIOD / 2) clock = ~clock;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_len = 0;
   int bytes_sent = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   rsp_item_type expected_q [$];
   logic [7:0] table_q [$];

   // Parser state as the block should hold it.
   phase_type parse_phase = PH_IDLE;
   logic [5:0] hdr_pos = '0;
   logic [15:0] entries_to_go = '0;
   logic [7:0] cur_type = '0;
   logic [4:0] ent_pos = '0;
   logic [31:0] cur_word = '0;
   logic [7:0] cur_id = '0;
   logic [4:0] cpus_seen = '0;
   logic [3:0] ioapics_seen = '0;
   logic [7:0] irq_map [ISA_IRQS];

   initial begin
      for (int i = 0; i < ISA_IRQS; i++) irq_map[i] = 8'(i);
   end

   task automatic restart_parse();
      parse_phase = PH_HEADER;
      hdr_pos = '0;
      entries_to_go = '0;
      cur_type = '0;
      ent_pos = '0;
      cur_word = '0;
      cur_id = '0;
      cpus_seen = '0;
      ioapics_seen = '0;
      for (int i = 0; i < ISA_IRQS; i++) irq_map[i] = 8'(i);
   endtask

   task automatic emit_map_and_done();
      rsp_item_type r;
      for (int i = 0; i < ISA_IRQS; i++) begin
         r = '0;
         r.kind = KIND_MAP;
         r.slot = 4'(i);
         r.gsi = irq_map[i];
         expected_q.push_back(r);
      end
      r = '0;
      r.kind = KIND_DONE;
      r.status = (cpus_seen != 0) ? STATUS_OK : STATUS_NO_CPUS;
      r.cpu_total = cpus_seen;
      r.ioapic_total = ioapics_seen;
      r.last = 1'b1;
      expected_q.push_back(r);
      parse_phase = PH_DONE;
   endtask

   task automatic parse_table_byte(input logic [7:0] b, input logic first);
      rsp_item_type r;
      int ent_len;
      if (first) restart_parse();
      if (parse_phase == PH_HEADER) begin
         if (hdr_pos < 4 && b != SIG_BYTES[hdr_pos[1:0]]) begin
            r = '0;
            r.kind = KIND_DONE;
            r.status = STATUS_BAD_SIG;
            r.last = 1'b1;
            expected_q.push_back(r);
            parse_phase = PH_DONE;
         end else begin
            if (hdr_pos == HDR_COUNT_LO) entries_to_go[7:0] = b;
            if (hdr_pos == HDR_COUNT_HI) entries_to_go[15:8] = b;
            hdr_pos++;
            if (hdr_pos >= HDR_LEN) begin
               parse_phase = PH_ENTRY;
               ent_pos = '0;
               if (entries_to_go == 0) emit_map_and_done();
            end
         end
      end else if (parse_phase == PH_ENTRY) begin
         if (ent_pos == 0) cur_type = b;
         else if (ent_pos == 1) cur_id = b;
         if (ent_pos >= 4 && ent_pos <= 7) cur_word[8 * (ent_pos - 4) +: 8] = b;
         if (cur_type == ENT_CPU && ent_pos == 3 && cpus_seen < CPU_LIMIT) begin
            r = '0;
            r.kind = KIND_CPU;
            r.slot = cpus_seen[3:0];
            r.unit_id = cur_id;
            r.enabled = b[0];
            r.boot_cpu = b[1];
            expected_q.push_back(r);
            cpus_seen++;
         end
         if (ent_pos == 7) begin
            if (cur_type == ENT_IOAPIC && ioapics_seen < IOAPIC_LIMIT) begin
               r = '0;
               r.kind = KIND_IOAPIC;
               r.slot = ioapics_seen;
               r.unit_id = cur_id;
               r.mmio_base = cur_word;
               expected_q.push_back(r);
               ioapics_seen++;
            end else if (cur_type == ENT_OVERRIDE && cur_word[15:8] < ISA_IRQS) begin
               irq_map[cur_word[11:8]] = b;
            end
         end
         ent_len = (cur_type == ENT_CPU) ? CPU_ENT_LEN : ENT_LEN;
         ent_pos++;
         if (ent_pos >= ent_len) begin
            ent_pos = '0;
            cur_word = '0;
            entries_to_go--;
            if (entries_to_go == 0) emit_map_and_done();
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.table_byte <= b;
      req_chan.first <= first;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      bytes_sent++;
      parse_table_byte(b, first);
   endtask

   task automatic send_table(input int count);
      for (int i = 0; i < count && i < table_q.size(); i++) send_byte(table_q[i], i == 0);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic add_entry(input logic [7:0] ent_kind, input logic [7:0] id,
                            input logic [7:0] flags, input logic [31:0] word);
      int len;
      len = (ent_kind == ENT_CPU) ? CPU_ENT_LEN : ENT_LEN;
      table_q.push_back(ent_kind);
      table_q.push_back(id);
      table_q.push_back(8'($urandom));
      table_q.push_back(flags);
      for (int i = 0; i < 4; i++) table_q.push_back(word[8 * i +: 8]);
      for (int i = 8; i < len; i++) table_q.push_back(8'($urandom));
   endtask

   task automatic add_random_entry();
      int pick;
      logic [7:0] ent_kind;
      logic [31:0] word;
      pick = $urandom_range(99);
      word = $urandom;
      if (pick < 35) begin
         ent_kind = ENT_CPU;
      end else if (pick < 60) begin
         ent_kind = ENT_IOAPIC;
      end else if (pick < 85) begin
         ent_kind = ENT_OVERRIDE;
         if ($urandom_range(3) != 0) word[15:8] = 8'($urandom_range(ISA_IRQS - 1));
      end else begin
         ent_kind = 8'($urandom);
      end
      add_entry(ent_kind, 8'($urandom), 8'($urandom), word);
   endtask

   task automatic build_table(input int n_entries, input logic [15:0] count);
      table_q.delete();
      for (int i = 0; i < HDR_LEN; i++) table_q.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) table_q[i] = SIG_BYTES[i];
      table_q[HDR_COUNT_LO] = count[7:0];
      table_q[HDR_COUNT_HI] = count[15:8];
      repeat (n_entries) add_random_entry();
   endtask

   task automatic send_random_table();
      int n;
      int style;
      int upto;
      n = $urandom_range(5);
      build_table(n, 16'(n));
      style = $urandom_range(99);
      upto = table_q.size();
      if (style < 8) table_q[$urandom_range(3)] = 8'($urandom);
      else if (style < 15) table_q[HDR_COUNT_HI] = 8'($urandom_range(1, 255));
      else if (style < 25) upto = $urandom_range(1, table_q.size());
      send_table(upto);
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic test_ignored_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(SIG_BYTES[0], 1'b0);
      wait_drained();
   endtask

   task automatic test_bad_signature();
      for (int k = 0; k < 4; k++) begin
         build_table(0, 16'd0);
         table_q[k] = table_q[k] ^ 8'h01;
         send_table(k + 3);
      end
      wait_drained();
   endtask

   task automatic test_empty_table();
      build_table(0, 16'd0);
      send_table(table_q.size());
      wait_drained();
   endtask

   task automatic test_entry_kinds();
      build_table(0, 16'd9);
      add_entry(ENT_CPU, 8'hFF, 8'h03, $urandom);
      add_entry(ENT_CPU, 8'h00, 8'h00, $urandom);
      add_entry(ENT_IOAPIC, 8'hA5, $urandom, 32'hFEC0_0000);
      add_entry(ENT_IOAPIC, 8'h00, $urandom, 32'hFFFF_FFFF);
      add_entry(ENT_OVERRIDE, $urandom, $urandom, {8'd2, 8'h5A, 8'd0, 8'hA5});
      add_entry(ENT_OVERRIDE, $urandom, $urandom, {8'hFF, 8'h00, 8'd15, 8'h00});
      add_entry(ENT_OVERRIDE, $urandom, $urandom, {8'h33, 8'h00, 8'd16, 8'h00});
      add_entry(8'd1, $urandom, $urandom, $urandom);
      add_entry(8'hFF, $urandom, $urandom, $urandom);
      send_table(table_q.size());
      wait_drained();
   endtask

   task automatic test_restart();
      build_table(2, 16'hFFFF);
      send_table(table_q.size());
      build_table(0, 16'd0);
      send_table(20);
      build_table(1, 16'd1);
      send_table(table_q.size());
      wait_drained();
   endtask

   task automatic test_limits();
      build_table(0, 16'd30);
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 2) add_entry(ENT_IOAPIC, $urandom, $urandom, $urandom);
         else add_entry(ENT_CPU, $urandom, $urandom, $urandom);
      end
      send_table(table_q.size());
      wait_drained();
   endtask

   task automatic test_backpressure();
      build_table(0, 16'd6);
      for (int i = 0; i < 3; i++) begin
         add_entry(ENT_CPU, $urandom, $urandom, $urandom);
         add_entry(ENT_IOAPIC, $urandom, $urandom, $urandom);
      end
      hold_len = HOLD_CYCLES;
      send_table(table_q.size());
      wait_drained();
   endtask

   task automatic test_random_tables();
      int mark;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE[p];
         stall_pct = RECV_STALL[p];
         mark = bytes_sent;
         while (bytes_sent - mark < PHASE_BYTES) send_random_table();
         wait_drained();
      end
   endtask

   initial begin : drive_ready
      int held;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len != 0) begin
            rsp_chan.ready <= 1'b0;
            for (held = 0; held < hold_len; held++) @(posedge clock);
            hold_len = 0;
         end
         rsp_chan.ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            $error("result transfer with none expected: kind %0d slot %0d",
                   rsp_chan.kind, rsp_chan.slot);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("kind", want.kind, rsp_chan.kind);
            check_field("slot", want.slot, rsp_chan.slot);
            check_field("unit_id", want.unit_id, rsp_chan.unit_id);
            check_field("enabled", want.enabled, rsp_chan.enabled);
            check_field("boot_cpu", want.boot_cpu, rsp_chan.boot_cpu);
            check_field("mmio_base", want.mmio_base, rsp_chan.mmio_base);
            check_field("gsi", want.gsi, rsp_chan.gsi);
            check_field("status", want.status, rsp_chan.status);
            check_field("cpu_total", want.cpu_total, rsp_chan.cpu_total);
            check_field("ioapic_total", want.ioapic_total, rsp_chan.ioapic_total);
            check_field("last", want.last, rsp_chan.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("mp_config_table_parser_test: errors");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.table_byte = '0;
      req_chan.first = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_ignored_bytes();
      test_bad_signature();
      test_empty_table();
      test_entry_kinds();
      test_restart();
      test_limits();
      test_backpressure();
      test_random_tables();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0)
         $display("mp_config_table_parser_test: clean");
      else
         $display("mp_config_table_parser_test: errors");
      $finish;
   end

endmodule
